// ===== hw/rtl/gb5_pkg.sv =====
package gb5_pkg;

	// payload and register widths
	localparam int PIX_W = 8;
	localparam int RES_W = 16;
	localparam int FW_W = 11;
	localparam int FH_W = 13;
	localparam int ROW_W = 13;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// kernel geometry
	localparam int KSIZE = 5;
	localparam int HALF_K = KSIZE / 2;
	localparam int LINES = KSIZE - 1;
	localparam int MAX_HEIGHT = 4096;

	// fixed point: Q0.16 taps, Q8.8 result
	localparam int COEF_W = 14;
	localparam int SUM_W = 24;
	localparam int FRAC_SHIFT = 8;

	localparam logic [FW_W-1:0] FW_RESET = 11'd640;
	localparam logic [FH_W-1:0] FH_RESET = 13'd480;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [LINES-1:0] line_word_t;

	// per-word result tags
	typedef struct packed {
		logic border;
		logic last;
	} gb5_tag_t;

	// control of the first pipeline stage
	typedef struct packed {
		logic     valid;
		logic     emit;
		gb5_tag_t tag;
	} gb5_s1_t;

	localparam logic [COEF_W-1:0] COEF [KSIZE][KSIZE] = '{
		'{14'd247,  14'd984,  14'd1559, 14'd984,  14'd247},
		'{14'd984,  14'd3926, 14'd6220, 14'd3926, 14'd984},
		'{14'd1559, 14'd6220, 14'd9853, 14'd6220, 14'd1559},
		'{14'd984,  14'd3926, 14'd6220, 14'd3926, 14'd984},
		'{14'd247,  14'd984,  14'd1559, 14'd984,  14'd247}
	};

endpackage

// ===== hw/rtl/gb5_pix_if.sv =====
interface gb5_pix_if;
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [gb5_pkg::PIX_W-1:0] pixel;

	modport source (output valid, cmd, pixel, input ready);
	modport sink (input valid, cmd, pixel, output ready);
endinterface

// ===== hw/rtl/gb5_res_if.sv =====
interface gb5_res_if;
	logic                     valid;
	logic                     ready;
	logic [gb5_pkg::RES_W-1:0] smoothed;
	logic                     on_border;
	logic                     frame_end;

	modport source (output valid, smoothed, on_border, frame_end, input ready);
	modport sink (input valid, smoothed, on_border, frame_end, output ready);
endinterface

// ===== hw/rtl/gb5_regs.sv =====
module gb5_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gb5_pkg::APB_AW-1:0]  paddr,
	input  logic [gb5_pkg::APB_DW-1:0]  pwdata,
	output logic [gb5_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [gb5_pkg::FW_W-1:0]    frame_width,
	output logic [gb5_pkg::FH_W-1:0]    frame_height,
	output logic                        restart
);
	import gb5_pkg::*;

	logic     wr;
	reg_idx_t idx;
	logic [FW_W-1:0] fw_q;
	logic [FH_W-1:0] fh_q;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;
	assign idx = reg_idx_t'(paddr[2]);
	assign restart = wr;
	assign frame_width = fw_q;
	assign frame_height = fh_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_RESET;
			fh_q <= FH_RESET;
		end else if (wr) begin
			case (idx)
				REG_FRAME_WIDTH:  fw_q <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: fh_q <= pwdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_FRAME_WIDTH:  prdata = APB_DW'(fw_q);
			REG_FRAME_HEIGHT: prdata = APB_DW'(fh_q);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/gb5_line_mem.sv =====
module gb5_line_mem #(
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output gb5_pkg::line_word_t        rd_data,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  gb5_pkg::line_word_t        wr_data
);
	import gb5_pkg::*;

	line_word_t mem [DEPTH];

	// one column of the four stored lines per entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, new data forwarded on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end

endmodule

// ===== hw/rtl/gb5_ctrl.sv =====
module gb5_ctrl #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [gb5_pkg::FW_W-1:0]       frame_width,
	input  logic [gb5_pkg::FH_W-1:0]       frame_height,
	input  logic                           restart,
	gb5_pix_if.sink                        pix,
	input  logic                           s1_take,
	output gb5_pkg::gb5_s1_t               s1,
	output logic [$clog2(MAX_WIDTH)-1:0]   s1_col,
	output gb5_pkg::pix_t                  s1_pixel,
	output logic                           rd_en,
	output logic [$clog2(MAX_WIDTH)-1:0]   rd_addr
);
	import gb5_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CW = COL_W + 2;
	localparam int HW = ROW_W + 1;

	logic [CW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic accept;
	logic inside_frame;
	logic processed;
	logic col_wrap;
	logic out_wrap;
	logic emit;
	logic border;
	logic last;
	logic s1_valid_q;
	logic s1_emit_q;
	gb5_tag_t s1_tag_q;
	logic [COL_W-1:0] s1_col_q;
	pix_t s1_px_q;

	// effective frame size, clamped to the supported range
	always_comb begin
		if (frame_width == '0) begin
			w_eff = CW'(1);
		end else if (32'(frame_width) > MAX_WIDTH) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(frame_width);
		end
		if (frame_height == '0) begin
			h_eff = HW'(1);
		end else if (HW'(frame_height) > HW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(frame_height);
		end
	end

	// decisions for the word at the input
	assign accept = pix.valid && pix.ready;
	assign inside_frame = HW'(in_row_q) < h_eff;
	assign processed = !(pix.cmd == CMD_FLUSH && inside_frame);
	assign col_wrap = CW'(in_col_q) + CW'(1) >= w_eff;
	assign out_wrap = CW'(out_col_q) + CW'(1) >= w_eff;

	// a result leaves once the input is two rows and two pixels ahead
	assign emit = (in_row_q >= ROW_W'(4)) ||
		(in_row_q == ROW_W'(3) && w_eff != CW'(1)) ||
		(in_row_q == ROW_W'(2) && in_col_q >= COL_W'(2));

	assign border = (out_row_q < ROW_W'(HALF_K)) || (out_col_q < COL_W'(HALF_K)) ||
		(HW'(out_row_q) + HW'(HALF_K + 1) > h_eff) ||
		(CW'(out_col_q) + CW'(HALF_K + 1) > w_eff);
	assign last = (HW'(out_row_q) + HW'(1) >= h_eff) && out_wrap;

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart || (accept && processed && emit && last)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept && processed) begin
			in_col_q <= col_wrap ? '0 : in_col_q + COL_W'(1);
			if (col_wrap) begin
				in_row_q <= in_row_q + ROW_W'(1);
			end
			if (emit) begin
				out_col_q <= out_wrap ? '0 : out_col_q + COL_W'(1);
				if (out_wrap) begin
					out_row_q <= out_row_q + ROW_W'(1);
				end
			end
		end
	end

	// first stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pix.ready) begin
			s1_valid_q <= accept && processed;
		end
	end

	// first stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_emit_q       <= emit;
			s1_tag_q.border <= border;
			s1_tag_q.last   <= last;
			s1_col_q        <= in_col_q;
			s1_px_q         <= inside_frame ? pix.pixel : '0;
		end
	end

	assign pix.ready = !s1_valid_q || s1_take;
	assign rd_en = accept && processed;
	assign rd_addr = in_col_q;
	assign s1 = '{valid: s1_valid_q, emit: s1_emit_q, tag: s1_tag_q};
	assign s1_col = s1_col_q;
	assign s1_pixel = s1_px_q;

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && processed && emit && last |=>
		in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0)
		else $error("counters not cleared after last word of frame");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(in_col_q) < w_eff && CW'(out_col_q) < w_eff)
		else $error("column counter beyond frame width");

endmodule

// ===== hw/rtl/gb5_filter.sv =====
module gb5_filter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gb5_pkg::gb5_s1_t     s1,
	input  gb5_pkg::pix_t        s1_pixel,
	input  gb5_pkg::line_word_t  rd_data,
	output logic                 s1_take,
	output logic                 wr_en,
	output gb5_pkg::line_word_t  wr_data,
	gb5_res_if.source            res
);
	import gb5_pkg::*;

	pix_t vec [KSIZE];
	pix_t win_q [KSIZE][KSIZE];
	logic s1_move;
	logic out_free;
	logic rdy2;
	logic rdy3;
	logic s2_valid_q;
	gb5_tag_t s2_tag_q;
	logic [SUM_W-1:0] row_sum [KSIZE];
	logic [SUM_W-1:0] row_s3 [KSIZE];
	pix_t center_s3;
	gb5_tag_t tag_s3;
	logic s3_valid_q;
	logic [SUM_W-1:0] total;
	logic [RES_W-1:0] value;
	logic o_valid_q;
	logic [RES_W-1:0] smoothed_q;
	logic on_border_q;
	logic frame_end_q;

	// stage handshakes
	assign out_free = !o_valid_q || res.ready;
	assign rdy3 = !s3_valid_q || out_free;
	assign rdy2 = !s2_valid_q || rdy3;
	assign s1_take = rdy2;
	assign s1_move = s1.valid && rdy2;

	// new column: four stored lines plus the incoming pixel
	always_comb begin
		for (int k = 0; k < LINES; k++) begin
			vec[k] = rd_data[k];
		end
		vec[LINES] = s1_pixel;
		for (int k = 0; k < LINES; k++) begin
			wr_data[k] = vec[k+1];
		end
	end
	assign wr_en = s1_move;

	// window shifts one column left per processed word
	always_ff @(posedge clk) begin
		if (s1_move) begin
			for (int r = 0; r < KSIZE; r++) begin
				for (int c = 0; c < KSIZE - 1; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
				win_q[r][KSIZE-1] <= vec[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (rdy2) begin
			s2_valid_q <= s1_move && s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			s2_tag_q <= s1.tag;
		end
	end

	// weighted row sums
	always_comb begin
		for (int r = 0; r < KSIZE; r++) begin
			row_sum[r] = '0;
			for (int c = 0; c < KSIZE; c++) begin
				row_sum[r] = row_sum[r] + SUM_W'(win_q[r][c]) * SUM_W'(COEF[r][c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q <= 1'b0;
		end else if (rdy3) begin
			s3_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_valid_q && rdy3) begin
			row_s3    <= row_sum;
			center_s3 <= win_q[HALF_K][HALF_K];
			tag_s3    <= s2_tag_q;
		end
	end

	// final sum, Q8.8 truncation, border bypass
	always_comb begin
		total = '0;
		for (int r = 0; r < KSIZE; r++) begin
			total = total + row_s3[r];
		end
		if (tag_s3.border) begin
			value = {center_s3, FRAC_SHIFT'(0)};
		end else begin
			value = total[SUM_W-1:FRAC_SHIFT];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (out_free) begin
			o_valid_q <= s3_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_valid_q && out_free) begin
			smoothed_q  <= value;
			on_border_q <= tag_s3.border;
			frame_end_q <= tag_s3.last;
		end
	end

	assign res.valid = o_valid_q;
	assign res.smoothed = smoothed_q;
	assign res.on_border = on_border_q;
	assign res.frame_end = frame_end_q;

	a_border_frac: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.on_border |-> res.smoothed[FRAC_SHIFT-1:0] == '0)
		else $error("border word with fraction bits set");

	a_interior_max: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.on_border |-> res.smoothed <= RES_W'(65278))
		else $error("filtered word above kernel maximum");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && !rdy3 |=> s2_valid_q && $stable(win_q[HALF_K][HALF_K]) &&
		$stable(s2_tag_q))
		else $error("window changed under a stalled word");

endmodule

// ===== hw/rtl/gaussian_blur_5x5_unit.sv =====
// 5x5 gaussian smoothing of a raster-order 8-bit grey stream, Q8.8 results
// a result word reaches res via the first stage, window, row-sum and result registers
//   after the word completing its window (two rows plus two pixels on) is accepted
// throughput: one word per cycle unless res stalls, set by the line store, which
//   takes one read and one write per cycle
// reset: counters, valid flags and frame size (640 x 480) clear at once; the line
//   store is not cleared and takes no clearing pass
module gaussian_blur_5x5_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	gb5_pix_if.sink                     pix,
	gb5_res_if.source                   res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gb5_pkg::APB_AW-1:0]  paddr,
	input  logic [gb5_pkg::APB_DW-1:0]  pwdata,
	output logic [gb5_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import gb5_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic [FW_W-1:0]  frame_width;
	logic [FH_W-1:0]  frame_height;
	logic             restart;
	logic             s1_take;
	gb5_s1_t          s1;
	logic [COL_W-1:0] s1_col;
	pix_t             s1_pixel;
	logic             rd_en;
	logic [COL_W-1:0] rd_addr;
	line_word_t       rd_data;
	logic             wr_en;
	line_word_t       wr_data;

	// configuration registers
	gb5_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.restart      (restart)
	);

	// position tracking and first stage
	gb5_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.restart      (restart),
		.pix          (pix),
		.s1_take      (s1_take),
		.s1           (s1),
		.s1_col       (s1_col),
		.s1_pixel     (s1_pixel),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr)
	);

	// four line store
	gb5_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (s1_col),
		.wr_data (wr_data)
	);

	// window, weighted sum and result register
	gb5_filter u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1       (s1),
		.s1_pixel (s1_pixel),
		.rd_data  (rd_data),
		.s1_take  (s1_take),
		.wr_en    (wr_en),
		.wr_data  (wr_data),
		.res      (res)
	);

endmodule
